>>> design/sorted_table_insert_macros.svh
// assertion macros for the sorted table insert block
`ifndef SORTED_TABLE_INSERT_MACROS_SVH
`define SORTED_TABLE_INSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, clocked on clk, quiet during reset
`define STI_ASSERT_NOW(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sorted_table_insert: same-cycle check failed");

// next-cycle implication, clocked on clk, quiet during reset
`define STI_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sorted_table_insert: next-cycle check failed");

`else

`define STI_ASSERT_NOW(lbl, cond, prop)
`define STI_ASSERT_NEXT(lbl, cond, prop)

`endif

`endif

>>> design/sti_pkg.sv
// shared types and constants for the sorted table insert block
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

	localparam int DEPTH     = 256;
	localparam int KEY_WIDTH = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int POS_W     = 8;
	localparam int ENT_W     = 9;
	localparam int VAL_W     = 16;

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [VAL_W-1:0]     val_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// one read and one write on the table memory
	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		key_t wr_key;
		val_t wr_value;
	} mem_req_t;

	// registered read data
	typedef struct packed {
		key_t key;
		val_t value;
	} mem_rsp_t;

endpackage

`default_nettype wire

>>> design/sti_store.sv
// key and value table memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module sti_store
	import sti_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output mem_rsp_t      rsp
);

	key_t     key_mem [DEPTH];
	val_t     val_mem [DEPTH];
	mem_rsp_t rsp_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			key_mem[req.wr_addr] <= req.wr_key;
			val_mem[req.wr_addr] <= req.wr_value;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rsp_q.key   <= key_mem[req.rd_addr];
			rsp_q.value <= val_mem[req.rd_addr];
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> design/sorted_table_insert.sv
// Sorted key/value table with binary-search insert. Each request brings a key and a value;
// the block does a lower-bound binary search over the stored keys, each probe a read issue
// in S_SEARCH, then a compare of the registered read data in S_CMP, so at most
// p = ceil(log2(n+1)) probes for n stored entries. A key already present is reported as a
// duplicate with its index and nothing changes. Otherwise, if the table holds all DEPTH
// entries, the request is rejected as full; else every entry from the found index up moves
// one place higher, one entry per cycle through the single read and single write port of
// the table memory, and the new pair is written at the found index. While the output
// register is stalled the result waits in S_DONE: in_ready is low from acceptance until the
// result is loaded into the output register, and the next request is taken in the cycle
// after that at the earliest. The table needs no clearing after reset: only entries below
// the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_table_insert_macros.svh"

module sorted_table_insert
	import sti_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] key,
	input  wire logic [15:0] entry_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       position,
	output logic [8:0]       entries_after
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_DECIDE,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t   state_q;
	key_t     key_q;
	val_t     value_q;
	cnt_t     lo_q;
	cnt_t     hi_q;
	idx_t     mid_q;
	logic     dup_q;
	cnt_t     cnt_q;
	cnt_t     idx_q;
	logic     wb_pend_s1;
	idx_t     wb_addr_s1;
	status_t  res_status_q;
	cnt_t     res_pos_q;
	logic     out_valid_q;
	status_t  out_status_q;
	cnt_t     out_pos_q;
	cnt_t     out_cnt_q;

	cnt_t     mid;
	cnt_t     rd_idx;
	mem_req_t mem_req;
	mem_rsp_t mem_rsp;

	sti_store u_store (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	// probe midpoint and shift source index
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_idx = idx_q - cnt_t'(1);

	// memory requests from the sequencer
	always_comb begin
		mem_req          = '0;
		mem_req.wr_key   = key_q;
		mem_req.wr_value = value_q;
		case (state_q)
			S_SEARCH: begin
				mem_req.rd_en   = (lo_q < hi_q);
				mem_req.rd_addr = mid[IDX_W-1:0];
			end
			S_SHIFT: begin
				mem_req.rd_en   = (idx_q > lo_q);
				mem_req.rd_addr = rd_idx[IDX_W-1:0];
				if (wb_pend_s1) begin
					mem_req.wr_en    = 1'b1;
					mem_req.wr_addr  = wb_addr_s1;
					mem_req.wr_key   = mem_rsp.key;
					mem_req.wr_value = mem_rsp.value;
				end else if (idx_q == lo_q) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = lo_q[IDX_W-1:0];
				end
			end
			default: begin
				mem_req.rd_en = 1'b0;
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			wb_pend_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
			key_q        <= '0;
			value_q      <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			dup_q        <= 1'b0;
			idx_q        <= '0;
			wb_addr_s1   <= '0;
			res_status_q <= ST_INSERTED;
			res_pos_q    <= '0;
			out_status_q <= ST_INSERTED;
			out_pos_q    <= '0;
			out_cnt_q    <= '0;
		end else begin
			// result taken and nothing new to load this cycle
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q   <= key_t'(key);
						value_q <= entry_value;
						lo_q    <= '0;
						hi_q    <= cnt_q;
						dup_q   <= 1'b0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid[IDX_W-1:0];
						state_q <= S_CMP;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_CMP: begin
					if (mem_rsp.key < key_q) begin
						lo_q <= cnt_t'(mid_q) + cnt_t'(1);
					end else begin
						hi_q  <= cnt_t'(mid_q);
						dup_q <= (mem_rsp.key == key_q);
					end
					state_q <= S_SEARCH;
				end
				S_DECIDE: begin
					if (dup_q) begin
						res_status_q <= ST_DUPLICATE;
						res_pos_q    <= lo_q;
						state_q      <= S_DONE;
					end else if (cnt_q >= cnt_t'(DEPTH)) begin
						res_status_q <= ST_FULL;
						res_pos_q    <= '0;
						state_q      <= S_DONE;
					end else begin
						idx_q      <= cnt_q;
						wb_pend_s1 <= 1'b0;
						state_q    <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// move one entry up per cycle, then drop the new pair in
					if (idx_q > lo_q) begin
						idx_q      <= rd_idx;
						wb_pend_s1 <= 1'b1;
						wb_addr_s1 <= idx_q[IDX_W-1:0];
					end else begin
						wb_pend_s1 <= 1'b0;
						if (!wb_pend_s1) begin
							cnt_q        <= cnt_q + cnt_t'(1);
							res_status_q <= ST_INSERTED;
							res_pos_q    <= lo_q;
							state_q      <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_pos_q    <= res_pos_q;
						out_cnt_q    <= cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign position      = POS_W'(out_pos_q);
	assign entries_after = ENT_W'(out_cnt_q);

	// checks
	`STI_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= cnt_t'(DEPTH))
	`STI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`STI_ASSERT_NOW(a_full_result, out_valid_q && out_status_q == ST_FULL, out_pos_q == '0 && out_cnt_q == cnt_t'(DEPTH))
	`STI_ASSERT_NOW(a_insert_nonempty, out_valid_q && out_status_q == ST_INSERTED, out_cnt_q != '0 && out_pos_q < out_cnt_q)

endmodule

`default_nettype wire

>>> verif/sorted_table_insert_tb.sv
// testbench for the sorted key/value table insert block
`timescale 1ns / 1ps

module sorted_table_insert_tb;
	import sti_pkg::*;

	localparam int  RANDOM_ITEMS = 833;
	localparam int  CYCLE_LIMIT  = 1500000;
	localparam int  DRAIN_CYCLES = 300;
	localparam int  MAX_GAP      = 30;
	localparam int  PRINT_CAP    = 50;
	// kept out of the random keys so it is still absent once the table is full
	localparam key_t SPARE_KEY   = 32'h0000_0002;

	typedef struct packed {
		status_t    st;
		logic [7:0] pos;
		logic [8:0] fill;
	} outcome_t;

	typedef struct packed {
		key_t     k;
		val_t     v;
		bit       typed;
		outcome_t want;
	} sample_row_t;

	// opening rows on the empty table: extremes, duplicates, ordering
	localparam sample_row_t OPENING_ROWS [12] = '{
		'{32'h8000_0000, 16'h0000, 1'b1, '{ST_INSERTED,  8'd0, 9'd1}},
		'{32'h0000_0000, 16'hFFFF, 1'b1, '{ST_INSERTED,  8'd0, 9'd2}},
		'{32'hFFFF_FFFF, 16'h1234, 1'b1, '{ST_INSERTED,  8'd2, 9'd3}},
		'{32'h0000_0000, 16'h0005, 1'b1, '{ST_DUPLICATE, 8'd0, 9'd3}},
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{ST_DUPLICATE, 8'd2, 9'd3}},
		'{32'h8000_0000, 16'h0001, 1'b1, '{ST_DUPLICATE, 8'd1, 9'd3}},
		'{32'h7FFF_FFFF, 16'h8000, 1'b1, '{ST_INSERTED,  8'd1, 9'd4}},
		'{32'h8000_0001, 16'h7FFF, 1'b1, '{ST_INSERTED,  8'd3, 9'd5}},
		'{32'h0000_0001, 16'h00FF, 1'b1, '{ST_INSERTED,  8'd1, 9'd6}},
		'{32'hFFFF_FFFE, 16'hFF00, 1'b1, '{ST_INSERTED,  8'd5, 9'd7}},
		'{32'h5555_5555, 16'hAAAA, 1'b0, '{ST_INSERTED,  8'd0, 9'd0}},
		'{32'hAAAA_AAAA, 16'h5555, 1'b0, '{ST_INSERTED,  8'd0, 9'd0}}
	};

	// closing rows on the full table: duplicate while full, full rejection
	localparam sample_row_t CLOSING_ROWS [5] = '{
		'{32'hFFFF_FFFF, 16'h0000, 1'b1, '{ST_DUPLICATE, 8'd255, 9'd256}},
		'{32'h0000_0000, 16'hFFFF, 1'b1, '{ST_DUPLICATE, 8'd0,   9'd256}},
		'{SPARE_KEY,     16'h0000, 1'b1, '{ST_FULL,      8'd0,   9'd256}},
		'{SPARE_KEY,     16'hFFFF, 1'b1, '{ST_FULL,      8'd0,   9'd256}},
		'{32'h8000_0000, 16'h1111, 1'b0, '{ST_INSERTED,  8'd0,   9'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] key = '0;
	logic [15:0] entry_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  position;
	logic [8:0]  entries_after;

	// shadow copy of the table
	key_t shadow_keys [DEPTH];
	val_t shadow_vals [DEPTH];
	int   shadow_fill = 0;

	outcome_t awaited_outcomes [$];

	int tx_idle_pct = 14;
	int rx_idle_pct = 58;
	int accepted = 0;
	int checked = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int n_inserted = 0;
	int n_duplicate = 0;
	int n_full = 0;

	sorted_table_insert u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key          (key),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.position     (position),
		.entries_after(entries_after)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outcomes still awaited", cycle_count,
				awaited_outcomes.size());
			$display("sorted_table_insert_tb: errors");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// lower-bound search, then shift up and insert unless duplicate or full
	function automatic outcome_t place_symbol(input key_t k, input val_t v);
		outcome_t o;
		int slot;
		slot = 0;
		while (slot < shadow_fill && shadow_keys[slot] < k)
			slot++;
		if (slot < shadow_fill && shadow_keys[slot] == k) begin
			o.st = ST_DUPLICATE;
			o.pos = 8'(slot);
		end else if (shadow_fill >= DEPTH) begin
			o.st = ST_FULL;
			o.pos = '0;
		end else begin
			for (int i = shadow_fill; i > slot; i--) begin
				shadow_keys[i] = shadow_keys[i-1];
				shadow_vals[i] = shadow_vals[i-1];
			end
			shadow_keys[slot] = k;
			shadow_vals[slot] = v;
			shadow_fill++;
			o.st = ST_INSERTED;
			o.pos = 8'(slot);
		end
		o.fill = 9'(shadow_fill);
		return o;
	endfunction

	// new keys: mostly uniform, some at the ends, some next to stored keys
	function automatic key_t pick_fresh_key();
		key_t k;
		case ($urandom_range(9))
			0: k = key_t'($urandom_range(15));
			1: k = 32'hFFFF_FFFF - key_t'($urandom_range(15));
			2: k = (shadow_fill > 0) ? shadow_keys[$urandom_range(shadow_fill - 1)] + 1'b1
				: key_t'($urandom);
			3: k = (shadow_fill > 0) ? shadow_keys[$urandom_range(shadow_fill - 1)] - 1'b1
				: key_t'($urandom);
			default: k = key_t'($urandom);
		endcase
		if (k == SPARE_KEY)
			k = SPARE_KEY + 1'b1;
		return k;
	endfunction

	// one request: optional gap, hold until accepted, then predict
	task automatic push_request(input key_t k, input val_t v, input bit typed,
		input outcome_t typed_out);
		int gap;
		outcome_t got;
		if (accepted < 285) begin
			tx_idle_pct = 14;
			rx_idle_pct = 58;
		end else if (accepted < 570) begin
			tx_idle_pct = 58;
			rx_idle_pct = 14;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		entry_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = place_symbol(k, v);
		awaited_outcomes.push_back(typed ? typed_out : got);
		accepted++;
	endtask

	// stimulus
	initial begin
		int n;
		int dup_pct;
		key_t k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_ROWS[i])
			push_request(OPENING_ROWS[i].k, OPENING_ROWS[i].v, OPENING_ROWS[i].typed,
				OPENING_ROWS[i].want);

		// random part runs on until the table has filled
		n = 0;
		while (n < RANDOM_ITEMS || shadow_fill < DEPTH) begin
			dup_pct = (shadow_fill == DEPTH) ? 50 : 25;
			if (shadow_fill > 0 && $urandom_range(99) < dup_pct)
				k = shadow_keys[$urandom_range(shadow_fill - 1)];
			else
				k = pick_fresh_key();
			push_request(k, val_t'($urandom), 1'b0, '0);
			n++;
		end

		foreach (CLOSING_ROWS[i])
			push_request(CLOSING_ROWS[i].k, CLOSING_ROWS[i].v, CLOSING_ROWS[i].typed,
				CLOSING_ROWS[i].want);
		in_valid <= 1'b0;

		// wait out the remaining outcomes, then watch for strays
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d outcomes checked in %0d cycles", accepted, checked,
			cycle_count);
		$display("outcomes: %0d inserted, %0d duplicate, %0d table full, %0d mismatches",
			n_inserted, n_duplicate, n_full, mismatches);
		if (mismatches == 0)
			$display("sorted_table_insert_tb: clean");
		else
			$display("sorted_table_insert_tb: errors");
		$finish;
	end

	// outcome side: compare with the oldest prediction, then pick next ready
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_outcomes.size() == 0) begin
					flag_mismatch("outcome with no request waiting");
				end else begin
					want = awaited_outcomes.pop_front();
					checked++;
					if (status !== want.st)
						flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
					if (position !== want.pos)
						flag_mismatch($sformatf("position %0d, want %0d", position, want.pos));
					if (entries_after !== want.fill)
						flag_mismatch($sformatf("entries_after %0d, want %0d", entries_after,
							want.fill));
					case (want.st)
						ST_INSERTED: n_inserted++;
						ST_DUPLICATE: n_duplicate++;
						default: n_full++;
					endcase
				end
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

endmodule
